/* design/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types and codes of the multilevel feedback queue process selector
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int PID_W   = 16;
  localparam int WAIT_W  = 16;
  localparam int SLOT_FW = 6;
  localparam int LVL_FW  = 2;

  // operation codes on the input beat
  typedef enum logic [2:0] {
    OP_ADMIT     = 3'd0,
    OP_SET_STATE = 3'd1,
    OP_SET_WAIT  = 3'd2,
    OP_PICK      = 3'd3,
    OP_FREE      = 3'd4
  } op_t;

  // requested state codes of a set state beat
  typedef enum logic [1:0] {
    NS_SLEEPING = 2'd0,
    NS_RUNNABLE = 2'd1,
    NS_ZOMBIE   = 2'd2
  } new_state_t;

  // process state held in a table entry
  typedef enum logic [2:0] {
    PS_UNUSED   = 3'd0,
    PS_EMBRYO   = 3'd1,
    PS_SLEEPING = 3'd2,
    PS_RUNNABLE = 3'd3,
    PS_RUNNING  = 3'd4,
    PS_ZOMBIE   = 3'd5
  } pstate_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_RMW_RD = 3'd2,
    ST_UPDATE = 3'd3,
    ST_REPLY  = 3'd4
  } fsm_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_FW-1:0] slot;
    logic [1:0]        new_state;
    logic [WAIT_W-1:0] io_wait;
    logic [WAIT_W-1:0] cpu_delay;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_FW-1:0] chosen_slot;
    logic [PID_W-1:0]   chosen_pid;
    logic [LVL_FW-1:0]  run_level;
  } out_beat_t;

endpackage

/* design/mlfq_process_selector.sv */
// ----------------------------------------------------------------------------
// mlfq_process_selector
// process table with multilevel feedback queue selection of the next process
// ----------------------------------------------------------------------------
// The table of SLOTS entries lives in one synchronous memory with one read
// port; one beat is worked at a time. Admit and pick sweep the whole table,
// one entry per cycle through the read port, then wait for the last read to
// come back and close the sweep before the update and the reply. Set state
// and set wait counts do a read, modify and write of one entry; free and
// undefined codes skip the read and go straight to the update. The result
// goes into an output register, so a new beat is taken while a result still
// waits downstream. In-use bits sit in flip-flops and are cleared by reset at
// once, so the table needs no clearing pass after reset.
module mlfq_process_selector #(
  parameter int SLOTS  = 64,
  parameter int LEVELS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mlfq_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mlfq_pkg::out_beat_t  out_data
);

  localparam int IW    = $clog2(SLOTS);
  localparam int LW    = $clog2(LEVELS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // one table entry
  typedef struct packed {
    mlfq_pkg::pstate_t            st;
    logic [LW-1:0]                level;
    logic [mlfq_pkg::WAIT_W-1:0]  io;
    logic [mlfq_pkg::WAIT_W-1:0]  cpu;
    logic [mlfq_pkg::PID_W-1:0]   pid;
  } entry_t;

  localparam int DW = $bits(entry_t);

  // sequencer and beat registers
  mlfq_pkg::fsm_t              state_r, state_nxt;
  mlfq_pkg::in_beat_t          cmd_r;
  logic [mlfq_pkg::PID_W-1:0]  next_pid_r;

  // scan pipeline: address counter, then the registered memory read
  logic [CNT_W-1:0]            scan_cnt_r;
  logic                        pend_r;
  logic [IW-1:0]               idx_r;
  logic                        found_r;
  logic [IW-1:0]               best_idx_r;
  entry_t                      best_r;

  mlfq_pkg::out_beat_t         res_r, res_nxt;
  logic                        out_valid_r;
  mlfq_pkg::out_beat_t         out_data_r;

  // memory port signals
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic [DW-1:0]               q_data;
  logic                        q_used;
  entry_t                      q_ent;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  entry_t                      wr_ent;
  logic                        clr_en;

  logic                        accept;
  logic                        reply_load;
  logic                        scan_done;
  logic                        cand_take;
  logic [8:0]                  slot_ext;
  logic                        slot_ok;
  logic [IW-1:0]               slot_idx;
  logic [LW-1:0]               admit_lvl;
  logic [8:0]                  best_idx_ext;
  logic [3:0]                  best_lvl_ext;
  logic [3:0]                  admit_lvl_ext;

  // lower level first, then larger io wait, smaller cpu wait, larger pid
  function automatic logic better(entry_t a, entry_t b);
    logic r;
    if (a.level != b.level) begin
      r = (a.level < b.level);
    end else if (a.io != b.io) begin
      r = (a.io > b.io);
    end else if (a.cpu != b.cpu) begin
      r = (a.cpu < b.cpu);
    end else begin
      r = (a.pid > b.pid);
    end
    return r;
  endfunction

  mlfq_entry_store #(
    .DEPTH (SLOTS),
    .DW    (DW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .q_data   (q_data),
    .q_used   (q_used),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (DW'(wr_ent)),
    .clr_en   (clr_en),
    .clr_addr (slot_idx)
  );

  assign q_ent = entry_t'(q_data);

  // handshake
  assign in_stall   = (state_r != mlfq_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign reply_load = (state_r == mlfq_pkg::ST_REPLY) && (!out_valid_r || !out_stall);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // addressed slot, ignored when beyond the table
  assign slot_ext = 9'(cmd_r.slot);
  assign slot_ok  = (slot_ext < 9'(SLOTS));
  assign slot_idx = slot_ext[IW-1:0];

  // pids 1 and 2 start at the bottom level
  assign admit_lvl = ((next_pid_r == 16'd1) || (next_pid_r == 16'd2)) ?
                     LW'(LEVELS - 1) : '0;

  // output fields keep only their low bits
  assign best_idx_ext  = 9'(best_idx_r);
  assign best_lvl_ext  = 4'(best_r.level);
  assign admit_lvl_ext = 4'(admit_lvl);

  assign scan_done = (scan_cnt_r == CNT_W'(SLOTS)) && !pend_r;

  // candidate taken from the entry that just came back from memory
  always_comb begin
    cand_take = 1'b0;
    if (pend_r) begin
      if (cmd_r.op == mlfq_pkg::OP_ADMIT) begin
        cand_take = !q_used && !found_r;
      end else begin
        cand_take = q_used && (q_ent.st == mlfq_pkg::PS_RUNNABLE) &&
                    (!found_r || better(q_ent, best_r));
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlfq_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_data.op == mlfq_pkg::OP_ADMIT) || (in_data.op == mlfq_pkg::OP_PICK)) begin
            state_nxt = mlfq_pkg::ST_SCAN;
          end else if ((in_data.op == mlfq_pkg::OP_SET_STATE) ||
                       (in_data.op == mlfq_pkg::OP_SET_WAIT)) begin
            state_nxt = mlfq_pkg::ST_RMW_RD;
          end else begin
            state_nxt = mlfq_pkg::ST_UPDATE;
          end
        end
      end
      mlfq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = mlfq_pkg::ST_UPDATE;
        end
      end
      mlfq_pkg::ST_RMW_RD: begin
        state_nxt = mlfq_pkg::ST_UPDATE;
      end
      mlfq_pkg::ST_UPDATE: begin
        state_nxt = mlfq_pkg::ST_REPLY;
      end
      mlfq_pkg::ST_REPLY: begin
        if (reply_load) begin
          state_nxt = mlfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mlfq_pkg::ST_IDLE;
      end
    endcase
  end

  // memory accesses and the result of the beat
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_idx;
    wr_en   = 1'b0;
    wr_addr = best_idx_r;
    wr_ent  = q_ent;
    clr_en  = 1'b0;
    res_nxt = '0;
    unique case (state_r)
      mlfq_pkg::ST_SCAN: begin
        // one entry per cycle until the counter reaches the table size
        rd_en   = (scan_cnt_r < CNT_W'(SLOTS));
        rd_addr = scan_cnt_r[IW-1:0];
      end
      mlfq_pkg::ST_RMW_RD: begin
        rd_en = slot_ok;
      end
      mlfq_pkg::ST_UPDATE: begin
        unique case (cmd_r.op)
          mlfq_pkg::OP_ADMIT: begin
            if (found_r) begin
              wr_en                = 1'b1;
              wr_ent.st            = mlfq_pkg::PS_EMBRYO;
              wr_ent.level         = admit_lvl;
              wr_ent.io            = '0;
              wr_ent.cpu           = '0;
              wr_ent.pid           = next_pid_r;
              res_nxt.found        = 1'b1;
              res_nxt.chosen_slot  = best_idx_ext[5:0];
              res_nxt.chosen_pid   = next_pid_r;
              res_nxt.run_level    = admit_lvl_ext[1:0];
            end
          end
          mlfq_pkg::OP_PICK: begin
            if (found_r) begin
              wr_en     = 1'b1;
              wr_ent    = best_r;
              wr_ent.st = mlfq_pkg::PS_RUNNING;
              wr_ent.cpu = '0;
              // above the bottom level: demote and clear both counts
              if (best_r.level != LW'(LEVELS - 1)) begin
                wr_ent.level = best_r.level + 1'b1;
                wr_ent.io    = '0;
              end
              res_nxt.found       = 1'b1;
              res_nxt.chosen_slot = best_idx_ext[5:0];
              res_nxt.chosen_pid  = best_r.pid;
              res_nxt.run_level   = best_lvl_ext[1:0];
            end
          end
          mlfq_pkg::OP_SET_STATE: begin
            wr_addr = slot_idx;
            unique case (cmd_r.new_state)
              mlfq_pkg::NS_SLEEPING: begin
                wr_ent.st = mlfq_pkg::PS_SLEEPING;
                wr_en     = slot_ok && q_used;
              end
              mlfq_pkg::NS_RUNNABLE: begin
                wr_ent.st = mlfq_pkg::PS_RUNNABLE;
                wr_en     = slot_ok && q_used;
              end
              mlfq_pkg::NS_ZOMBIE: begin
                wr_ent.st = mlfq_pkg::PS_ZOMBIE;
                wr_en     = slot_ok && q_used;
              end
              default: begin
                // unknown state code is dropped
                wr_ent.st = q_ent.st;
              end
            endcase
          end
          mlfq_pkg::OP_SET_WAIT: begin
            wr_addr    = slot_idx;
            wr_ent.io  = cmd_r.io_wait;
            wr_ent.cpu = cmd_r.cpu_delay;
            wr_en      = slot_ok && q_used;
          end
          mlfq_pkg::OP_FREE: begin
            clr_en = slot_ok;
          end
          default: begin
            // undefined codes leave the table alone
            res_nxt = '0;
          end
        endcase
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // sequencer, scan and pid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mlfq_pkg::ST_IDLE;
      next_pid_r <= 16'd1;
      scan_cnt_r <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        scan_cnt_r <= '0;
        pend_r     <= 1'b0;
        found_r    <= 1'b0;
      end else if (state_r == mlfq_pkg::ST_SCAN) begin
        pend_r <= rd_en;
        if (rd_en) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (cand_take) begin
          found_r <= 1'b1;
        end
      end
      // pid advances only when admit got a slot
      if ((state_r == mlfq_pkg::ST_UPDATE) && (cmd_r.op == mlfq_pkg::OP_ADMIT) && found_r) begin
        next_pid_r <= next_pid_r + 1'b1;
      end
    end
  end

  // beat payload and running best entry
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (state_r == mlfq_pkg::ST_SCAN) begin
      idx_r <= rd_addr;
      if (cand_take) begin
        best_idx_r <= idx_r;
        best_r     <= q_ent;
      end
    end
    if (state_r == mlfq_pkg::ST_UPDATE) begin
      res_r <= res_nxt;
    end
    if (reply_load) begin
      out_data_r <= res_r;
    end
  end

  // output register, loaded when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (reply_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // an accepted beat blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accepting a beat");

  // the pid counter moves only on a successful admit
  a_pid_on_admit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (next_pid_r != $past(next_pid_r))) |->
    $past((state_r == mlfq_pkg::ST_UPDATE) && (cmd_r.op == mlfq_pkg::OP_ADMIT) && found_r))
    else $error("pid counter changed outside a successful admit");

  // a new result appears only out of the reply state
  a_result_from_reply: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == mlfq_pkg::ST_REPLY))
    else $error("result beat raised outside the reply state");

  // a table write never lands during the scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlfq_pkg::ST_SCAN) |-> (!wr_en && !clr_en))
    else $error("table written while scanning");

endmodule

/* design/mlfq_entry_store.sv */
// ----------------------------------------------------------------------------
// mlfq_entry_store
// process table memory with one registered read port, one write port and
// per-entry in-use bits; an entry not in use reads as all zero
// ----------------------------------------------------------------------------
module mlfq_entry_store #(
  parameter int DEPTH = 64,
  parameter int DW    = 53,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] q_data,
  output logic          q_used,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          clr_en,
  input  logic [AW-1:0] clr_addr
);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [DW-1:0]    rd_q_r;
  logic             rd_used_r;
  logic [DEPTH-1:0] used_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (wr_en) begin
        used_r[wr_addr] <= 1'b1;
      end else if (clr_en) begin
        used_r[clr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_used_r <= used_r[rd_addr];
      end
    end
  end

  assign q_used = rd_used_r;
  assign q_data = rd_used_r ? rd_q_r : '0;

endmodule

/* tb/mlfq_table_model_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_table_model_pkg
// scoreboard for the process selector: keeps its own copy of the process
// table, works out the reply owed for every accepted request beat and checks
// each reply beat field by field against the oldest one still owed
// ----------------------------------------------------------------------------
package mlfq_table_model_pkg;

  import mlfq_pkg::*;

  localparam int TBL_SLOTS  = 64;
  localparam int TBL_LEVELS = 4;
  localparam int REPORT_CAP = 60;

  class mlfq_table_model;

    pstate_t     st  [TBL_SLOTS];
    logic [1:0]  lvl [TBL_SLOTS];
    logic [15:0] io  [TBL_SLOTS];
    logic [15:0] cpu [TBL_SLOTS];
    logic [15:0] pid [TBL_SLOTS];
    logic [15:0] pid_next;
    out_beat_t   owed_replies[$];
    int unsigned mismatches;

    function new();
      for (int s = 0; s < TBL_SLOTS; s++) begin
        st[s]  = PS_UNUSED;
        lvl[s] = '0;
        io[s]  = '0;
        cpu[s] = '0;
        pid[s] = '0;
      end
      pid_next   = 16'd1;
      mismatches = 0;
    endfunction

    // larger io wait, then smaller cpu wait, then larger pid
    function bit outranks(int a, int b);
      if (io[a] != io[b]) return io[a] > io[b];
      if (cpu[a] != cpu[b]) return cpu[a] < cpu[b];
      return pid[a] > pid[b];
    endfunction

    function out_beat_t predict_reply(in_beat_t b);
      out_beat_t r;
      int        best;
      bit        done;
      r    = '0;
      done = 1'b0;
      case (b.op)
        OP_ADMIT: begin
          for (int s = 0; s < TBL_SLOTS; s++) begin
            if (!done && st[s] == PS_UNUSED) begin
              done     = 1'b1;
              st[s]    = PS_EMBRYO;
              pid[s]   = pid_next;
              pid_next = pid_next + 16'd1;
              io[s]    = '0;
              cpu[s]   = '0;
              lvl[s]   = (pid[s] == 16'd1 || pid[s] == 16'd2) ? 2'(TBL_LEVELS - 1) : 2'd0;
              r.found       = 1'b1;
              r.chosen_slot = 6'(s);
              r.chosen_pid  = pid[s];
              r.run_level   = lvl[s];
            end
          end
        end
        OP_SET_STATE: begin
          if (st[b.slot] != PS_UNUSED) begin
            case (b.new_state)
              NS_SLEEPING: st[b.slot] = PS_SLEEPING;
              NS_RUNNABLE: st[b.slot] = PS_RUNNABLE;
              NS_ZOMBIE:   st[b.slot] = PS_ZOMBIE;
              default: ;
            endcase
          end
        end
        OP_SET_WAIT: begin
          if (st[b.slot] != PS_UNUSED) begin
            io[b.slot]  = b.io_wait;
            cpu[b.slot] = b.cpu_delay;
          end
        end
        OP_PICK: begin
          for (int l = 0; l < TBL_LEVELS; l++) begin
            if (!done) begin
              best = -1;
              for (int s = 0; s < TBL_SLOTS; s++) begin
                if (st[s] == PS_RUNNABLE && lvl[s] == l && (best < 0 || outranks(s, best)))
                  best = s;
              end
              if (best >= 0) begin
                done          = 1'b1;
                r.found       = 1'b1;
                r.chosen_slot = 6'(best);
                r.chosen_pid  = pid[best];
                r.run_level   = 2'(l);
                st[best]      = PS_RUNNING;
                if (l != TBL_LEVELS - 1) begin
                  lvl[best] = 2'(l + 1);
                  io[best]  = '0;
                  cpu[best] = '0;
                end else begin
                  cpu[best] = '0;
                end
              end
            end
          end
        end
        OP_FREE: begin
          st[b.slot]  = PS_UNUSED;
          lvl[b.slot] = '0;
          io[b.slot]  = '0;
          cpu[b.slot] = '0;
          pid[b.slot] = '0;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(in_beat_t b);
      owed_replies.push_back(predict_reply(b));
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task check_reply(out_beat_t got);
      out_beat_t want;
      if (owed_replies.size() == 0) begin
        report("reply with nothing owed", '0, got);
        return;
      end
      want = owed_replies.pop_front();
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.chosen_slot !== want.chosen_slot)
        report("chosen_slot", want.chosen_slot, got.chosen_slot);
      if (got.chosen_pid !== want.chosen_pid)
        report("chosen_pid", want.chosen_pid, got.chosen_pid);
      if (got.run_level !== want.run_level)
        report("run_level", want.run_level, got.run_level);
    endtask

    function int pending();
      return owed_replies.size();
    endfunction

    // random slot that is in use, -1 on an empty table
    function int any_used_slot();
      int pool[$];
      for (int s = 0; s < TBL_SLOTS; s++)
        if (st[s] != PS_UNUSED) pool.push_back(s);
      if (pool.size() == 0) return -1;
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

  endclass

endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of mlfq_process_selector: a short directed sequence walks the
// special cases, then phases of random requests fill, churn and drain the
// process table; every reply is checked against the scoreboard's own table
// ----------------------------------------------------------------------------
module tb;

  import mlfq_pkg::*;
  import mlfq_table_model_pkg::*;

  localparam int RANDOM_BEATS    = 1300;
  localparam int PHASE_BEATS     = 120;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int HOLD_OFF_AT     = 150;   // reply count at which the long stall starts
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;

  // request mixes of the random phases
  localparam int MODE_FILL  = 0;
  localparam int MODE_CHURN = 1;
  localparam int MODE_DRAIN = 2;

  // codes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam logic [1:0] NS_BAD     = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  mlfq_table_model proc_table = new();
  int unsigned     cycles     = 0;
  int unsigned     beats_sent = 0;

  mlfq_process_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // both monitors sample the values from just before the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) proc_table.note_request(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) proc_table.check_reply(out_data);
  end

  function automatic in_beat_t beat(logic [2:0] op, logic [5:0] slot, logic [1:0] ns,
                                    logic [15:0] io, logic [15:0] cpu);
    in_beat_t b;
    b.op        = op;
    b.slot      = slot;
    b.new_state = ns;
    b.io_wait   = io;
    b.cpu_delay = cpu;
    return b;
  endfunction

  // wait counts lean toward zero, all ones and small values so ties are common
  function automatic logic [15:0] wait_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) return 16'h0000;
    if (k < 35) return 16'hFFFF;
    if (k < 60) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic in_beat_t random_beat(int mode);
    in_beat_t    b;
    logic [63:0] raw;
    int          k, j, used;
    int          t_admit, t_state, t_wait, t_pick, t_free;
    // every field starts fully random, so idle fields toggle too
    raw  = {$urandom, $urandom};
    b    = raw[$bits(in_beat_t)-1:0];
    used = proc_table.any_used_slot();
    // mostly aim at live entries, sometimes at any slot
    if (used >= 0 && $urandom_range(0, 9) != 0) b.slot = 6'(used);
    case (mode)
      MODE_FILL: begin
        t_admit = 60; t_state = 75; t_wait = 85; t_pick = 93; t_free = 97;
      end
      MODE_CHURN: begin
        t_admit = 12; t_state = 40; t_wait = 60; t_pick = 85; t_free = 96;
      end
      default: begin
        t_admit = 5;  t_state = 20; t_wait = 30; t_pick = 60; t_free = 96;
      end
    endcase
    k = $urandom_range(0, 99);
    if (k < t_admit) begin
      b.op = OP_ADMIT;
    end else if (k < t_state) begin
      b.op = OP_SET_STATE;
      j    = $urandom_range(0, 99);
      if (j < 70)      b.new_state = NS_RUNNABLE;
      else if (j < 82) b.new_state = NS_SLEEPING;
      else if (j < 94) b.new_state = NS_ZOMBIE;
      else             b.new_state = NS_BAD;
    end else if (k < t_wait) begin
      b.op        = OP_SET_WAIT;
      b.io_wait   = wait_value();
      b.cpu_delay = wait_value();
    end else if (k < t_pick) begin
      b.op = OP_PICK;
    end else if (k < t_free) begin
      b.op = OP_FREE;
    end else begin
      b.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    return b;
  endfunction

  // hold the beat until the block takes it; runs of zero gaps now and then
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = (beats_sent % 64 < 16) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // reply side: random stalls per beat, one long hold-off to back the block up
  initial begin : receiver
    int gap;
    int taken;
    out_stall = 1'b1;
    taken     = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else gap = (taken % 50 < 12) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int mode;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    mode     = MODE_FILL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: nothing runnable, requests on unused slots do nothing
    send_beat(beat(OP_PICK, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_SET_STATE, 6'd5, NS_RUNNABLE, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_WAIT, 6'd5, NS_SLEEPING, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_FREE, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    // pids 1 and 2 land on the bottom level, 3 and 4 on the top
    repeat (4) send_beat(beat(OP_ADMIT, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_SET_STATE, 6'd0, NS_RUNNABLE, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_STATE, 6'd2, NS_RUNNABLE, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_STATE, 6'd3, NS_RUNNABLE, 16'h0000, 16'h0000));
    // equal io wait, smaller cpu wait wins
    send_beat(beat(OP_SET_WAIT, 6'd2, NS_SLEEPING, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_SET_WAIT, 6'd3, NS_SLEEPING, 16'hFFFF, 16'h0000));
    // top level twice, then fall through to the bottom level
    repeat (3) send_beat(beat(OP_PICK, 6'h00, NS_SLEEPING, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_STATE, 6'd3, NS_BAD, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_STATE, 6'd2, NS_ZOMBIE, 16'h0000, 16'h0000));
    send_beat(beat(OP_SET_STATE, 6'd1, NS_SLEEPING, 16'h0000, 16'h0000));
    send_beat(beat(OP_SPARE_A, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_SPARE_B, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    send_beat(beat(OP_SPARE_C, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));
    // freed slot is reused by the next admit with a fresh pid
    send_beat(beat(OP_FREE, 6'd2, NS_SLEEPING, 16'h0000, 16'h0000));
    send_beat(beat(OP_ADMIT, 6'h00, NS_SLEEPING, 16'h0000, 16'h0000));
    // demoted entry runs again from level one
    send_beat(beat(OP_SET_STATE, 6'd3, NS_RUNNABLE, 16'h0000, 16'h0000));
    send_beat(beat(OP_PICK, 6'h3F, NS_BAD, 16'hFFFF, 16'hFFFF));

    // first phase fills the table past full, later phases mix at random
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % PHASE_BEATS == 0 && i != 0) mode = $urandom_range(MODE_FILL, MODE_DRAIN);
      send_beat(random_beat(mode));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (proc_table.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (proc_table.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
